[src/http_request_header_scanner_top_macros.svh]
// assertion macros shared by the queue and back-end modules
`ifndef HTTP_REQUEST_HEADER_SCANNER_TOP_MACROS_SVH
`define HTTP_REQUEST_HEADER_SCANNER_TOP_MACROS_SVH

// same-cycle implication
`define HRHS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HRHS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/hrhs_pkg.sv]
// types, codes and text constants of the request header scanner
`default_nettype none
package hrhs_pkg;

  localparam int NUM_METHODS  = 7;
  localparam int METHOD_CHARS = 8;
  localparam int HOST_KEY_LEN = 6;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = 2;
  localparam int QCNT_W       = 3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;

  typedef enum logic [2:0] {
    METH_GET,
    METH_POST,
    METH_PUT,
    METH_DELETE,
    METH_HEAD,
    METH_TRACE,
    METH_CONNECT,
    METH_UNKNOWN
  } method_t;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_INSIDE,
    PH_ENDED
  } phase_t;

  localparam logic [7:0] METHOD_TEXT [NUM_METHODS][METHOD_CHARS] = '{
    '{8'h47, 8'h45, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h55, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h20, 8'h00},
    '{8'h48, 8'h45, 8'h41, 8'h44, 8'h20, 8'h00, 8'h00, 8'h00},
    '{8'h54, 8'h52, 8'h41, 8'h43, 8'h45, 8'h20, 8'h00, 8'h00},
    '{8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h45, 8'h43, 8'h54, 8'h20}
  };

  localparam logic [3:0] METHOD_LEN [NUM_METHODS] = '{
    4'd4, 4'd5, 4'd4, 4'd7, 4'd5, 4'd6, 4'd8
  };

  localparam logic [7:0] HOST_KEY [HOST_KEY_LEN] = '{
    8'h48, 8'h6F, 8'h73, 8'h74, 8'h3A, 8'h20
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic       url_valid;
    logic [7:0] url_byte;
    logic       host_valid;
    logic [7:0] host_byte;
    logic       done_res;
    logic       accepted;
    method_t    method;
  } out_item_t;

  typedef struct packed {
    logic [7:0]              data_byte;
    logic                    last;
    logic [NUM_METHODS-1:0]  miss;
    logic [NUM_METHODS-1:0]  reached;
    logic [HOST_KEY_LEN-1:0] key_eq;
    logic                    is_space;
    logic                    is_nl;
  } cls_item_t;

endpackage
`default_nettype wire

[src/hrhs_front.sv]
// front end: accepts request bytes, tracks position and classifies each byte
`default_nettype none
module hrhs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  hrhs_pkg::in_item_t  in_item,
  input  logic                q_full,
  output logic                q_push,
  output hrhs_pkg::cls_item_t q_data
);
  import hrhs_pkg::*;

  logic [3:0] pos;
  logic [3:0] pos_next;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    pos_next = (pos == 4'hF) ? pos : pos + 4'd1;
    q_data.data_byte = in_item.data_byte;
    q_data.last      = in_item.last;
    for (int c = 0; c < NUM_METHODS; c++) begin
      q_data.miss[c]    = (pos < METHOD_LEN[c]) &&
                          (in_item.data_byte != METHOD_TEXT[c][pos[2:0]]);
      q_data.reached[c] = (pos_next >= METHOD_LEN[c]);
    end
    for (int k = 0; k < HOST_KEY_LEN; k++) begin
      q_data.key_eq[k] = (in_item.data_byte == HOST_KEY[k]);
    end
    q_data.is_space = (in_item.data_byte == CH_SPACE);
    q_data.is_nl    = (in_item.data_byte == CH_NL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 4'd0;
    end else if (q_push) begin
      pos <= in_item.last ? 4'd0 : pos_next;
    end
  end

endmodule
`default_nettype wire

[src/hrhs_queue.sv]
// short queue of classified items between front and back
`default_nettype none
module hrhs_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  hrhs_pkg::cls_item_t push_data,
  input  logic                pop,
  output hrhs_pkg::cls_item_t pop_data,
  output logic                full,
  output logic                empty
);
  import hrhs_pkg::*;
  `include "http_request_header_scanner_top_macros.svh"

  cls_item_t          slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `HRHS_ASSERT_IMP(a_queue_bound, 1'b1, count <= QCNT_W'(QDEPTH), "queue count overrun")

endmodule
`default_nettype wire

[src/hrhs_back.sv]
// back end: method, url and host scan state, result register
`default_nettype none
module hrhs_back #(
  parameter int URL_MAX  = 1024,
  parameter int HOST_MAX = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  hrhs_pkg::cls_item_t q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output hrhs_pkg::out_item_t out_item
);
  import hrhs_pkg::*;
  `include "http_request_header_scanner_top_macros.svh"

  localparam int URL_LEN_W  = $clog2(URL_MAX);
  localparam int HOST_LEN_W = $clog2(HOST_MAX);
  localparam logic [URL_LEN_W-1:0]  URL_LIMIT  = URL_LEN_W'(URL_MAX - 1);
  localparam logic [HOST_LEN_W-1:0] HOST_LIMIT = HOST_LEN_W'(HOST_MAX - 1);
  localparam logic [2:0] KEY_DONE = 3'(HOST_KEY_LEN);

  logic [NUM_METHODS-1:0] cands, cands_next;
  phase_t                 url_phase, url_phase_next;
  logic [URL_LEN_W-1:0]   url_len, url_len_next;
  logic [2:0]             host_cnt, host_cnt_next;
  phase_t                 host_phase, host_phase_next;
  logic [HOST_LEN_W-1:0]  host_len, host_len_next;
  logic                   ovf, ovf_next;
  logic                   url_emit, host_emit;
  logic                   has_result;
  method_t                meth;
  out_item_t              res;

  assign q_pop = !q_empty && (!out_valid || !out_stall);

  // next state
  always_comb begin
    cands_next      = cands & ~q_data.miss;
    url_phase_next  = url_phase;
    url_len_next    = url_len;
    host_cnt_next   = host_cnt;
    host_phase_next = host_phase;
    host_len_next   = host_len;
    ovf_next        = ovf;
    url_emit        = 1'b0;
    host_emit       = 1'b0;

    unique case (url_phase)
      PH_INSIDE: begin
        if (q_data.is_space) begin
          url_phase_next = PH_ENDED;
        end else if (url_len < URL_LIMIT) begin
          url_emit     = 1'b1;
          url_len_next = url_len + 1'b1;
        end else begin
          ovf_next = 1'b1;
        end
      end
      PH_WAIT: begin
        if (q_data.is_space) begin
          url_phase_next = PH_INSIDE;
        end
      end
      default: ;
    endcase

    unique case (host_phase)
      PH_INSIDE: begin
        if (q_data.is_nl) begin
          host_phase_next = PH_ENDED;
        end else if (host_len < HOST_LIMIT) begin
          host_emit     = 1'b1;
          host_len_next = host_len + 1'b1;
        end else begin
          ovf_next = 1'b1;
        end
      end
      PH_WAIT: begin
        if ((host_cnt < KEY_DONE) && q_data.key_eq[host_cnt]) begin
          host_cnt_next = host_cnt + 3'd1;
        end else begin
          host_cnt_next = q_data.key_eq[0] ? 3'd1 : 3'd0;
        end
        if (host_cnt_next == KEY_DONE) begin
          host_phase_next = PH_INSIDE;
        end
      end
      default: ;
    endcase
  end

  // result
  always_comb begin
    meth = METH_UNKNOWN;
    for (int c = NUM_METHODS - 1; c >= 0; c--) begin
      if (cands_next[c] && q_data.reached[c]) begin
        meth = method_t'(3'(c));
      end
    end
    has_result     = url_emit || host_emit || q_data.last;
    res.url_valid  = url_emit;
    res.url_byte   = url_emit ? q_data.data_byte : 8'h00;
    res.host_valid = host_emit;
    res.host_byte  = host_emit ? q_data.data_byte : 8'h00;
    res.done_res   = q_data.last;
    res.accepted   = q_data.last && (meth != METH_UNKNOWN) &&
                     (url_phase_next == PH_ENDED) &&
                     (host_phase_next == PH_ENDED) && !ovf_next;
    res.method     = q_data.last ? meth : METH_UNKNOWN;
  end

  always_ff @(posedge clk) begin
    if (rst || (q_pop && q_data.last)) begin
      cands      <= '1;
      url_phase  <= PH_WAIT;
      url_len    <= '0;
      host_cnt   <= 3'd0;
      host_phase <= PH_WAIT;
      host_len   <= '0;
      ovf        <= 1'b0;
    end else if (q_pop) begin
      cands      <= cands_next;
      url_phase  <= url_phase_next;
      url_len    <= url_len_next;
      host_cnt   <= host_cnt_next;
      host_phase <= host_phase_next;
      host_len   <= host_len_next;
      ovf        <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && has_result) begin
      out_item <= res;
    end
  end

  `HRHS_ASSERT_IMP(a_accept_known, out_valid && out_item.accepted,
    out_item.done_res && (out_item.method != METH_UNKNOWN), "accepted item without method")
  `HRHS_ASSERT_NXT(a_clear_on_last, q_pop && q_data.last,
    (url_phase == PH_WAIT) && (host_phase == PH_WAIT) && (cands == '1) && !ovf,
    "scan state not cleared after last byte")
  `HRHS_ASSERT_IMP(a_url_bound, q_pop && url_emit, url_len < URL_LIMIT,
    "url emitted past limit")

endmodule
`default_nettype wire

[src/http_request_header_scanner_top.sv]
// an accepted byte goes into a queue slot; its result is then registered in out_item
// throughput: one byte per cycle when not stalled; each pop updates the back-end scan state
// a four-entry queue between front and back absorbs output stalls
// reset: synchronous rst clears the queue, byte position, scan state and output valid
// after the last byte of a request the scan state returns to its reset values
`default_nettype none
module http_request_header_scanner_top #(
  parameter int URL_MAX  = 1024,
  parameter int HOST_MAX = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  hrhs_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output hrhs_pkg::out_item_t out_item
);
  import hrhs_pkg::*;

  cls_item_t push_data;
  cls_item_t pop_data;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;

  hrhs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  hrhs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  hrhs_back #(
    .URL_MAX  (URL_MAX),
    .HOST_MAX (HOST_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

[sim/tb.sv]
// testbench for the request header scanner: directed and random requests checked against a scan model
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hrhs_pkg::*;

  localparam int URL_MAX      = 1024;
  localparam int HOST_MAX     = 16;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_BYTES  = 40;
  localparam int NUM_PHASES   = 4;
  localparam int NUM_ROWS     = 16;
  // caret in the table text stands for a zero byte
  localparam logic [7:0] ZERO_MARK = 8'h5E;

  typedef struct {
    string   text;
    bit      typed;
    bit      acc;
    method_t meth;
  } request_row_t;

  request_row_t request_table [NUM_ROWS] = '{
    '{"GET /a Host: h\n",                  1'b1, 1'b1, METH_GET},
    '{"POST / Host: x\n",                  1'b1, 1'b1, METH_POST},
    '{"PUT \377^ Host: ^\377\015\n",       1'b1, 1'b1, METH_PUT},
    '{"DELETE u Host: v\n",                1'b1, 1'b1, METH_DELETE},
    '{"HEAD / Host: q\n",                  1'b1, 1'b1, METH_HEAD},
    '{"TRACE * Host: t\n",                 1'b1, 1'b1, METH_TRACE},
    '{"CONNECT h:1 Host: h\n",             1'b1, 1'b1, METH_CONNECT},
    '{"Host: ab c\n",                      1'b0, 1'b0, METH_UNKNOWN},
    '{"GET /x",                            1'b1, 1'b0, METH_GET},
    '{"GET / Host: h",                     1'b1, 1'b0, METH_GET},
    '{"GET / \n",                          1'b1, 1'b0, METH_GET},
    '{"GXT / Host: h\n",                   1'b1, 1'b0, METH_UNKNOWN},
    '{"GE",                                1'b1, 1'b0, METH_UNKNOWN},
    '{"GET / Host: 0123456789abcdef\n",    1'b1, 1'b0, METH_GET},
    '{"GET / Host: 0123456789abcde\n",     1'b1, 1'b1, METH_GET},
    '{"GET / HHost: z\n",                  1'b0, 1'b0, METH_UNKNOWN}
  };

  int idle_by_phase  [NUM_PHASES] = '{0, 67, 0, 7};
  int stall_by_phase [NUM_PHASES] = '{0, 0, 67, 7};

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int   idle_pct    = 0;
  int   stall_pct   = 0;
  int   fail_count  = 0;
  int   cycle_count = 0;
  int   hold_left   = 0;
  logic hold_req    = 1'b0;
  logic hold_ack    = 1'b0;

  logic [7:0] req_bytes [$];
  out_item_t  pending_results [$];

  logic [3:0]             scan_pos;
  logic [NUM_METHODS-1:0] method_live;
  phase_t                 url_state;
  logic [10:0]            url_count;
  logic [2:0]             key_count;
  phase_t                 host_state;
  logic [4:0]             host_count;
  logic                   too_long;

  http_request_header_scanner_top #(
    .URL_MAX  (URL_MAX),
    .HOST_MAX (HOST_MAX)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 50) $display("cycle %0d: %s", cycle_count, what);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = pending_results.pop_front();
        check_field("url_valid", 8'(out_item.url_valid), 8'(want.url_valid));
        check_field("url_byte", out_item.url_byte, want.url_byte);
        check_field("host_valid", 8'(out_item.host_valid), 8'(want.host_valid));
        check_field("host_byte", out_item.host_byte, want.host_byte);
        check_field("done_res", 8'(out_item.done_res), 8'(want.done_res));
        check_field("accepted", 8'(out_item.accepted), 8'(want.accepted));
        check_field("method", 8'(out_item.method), 8'(want.method));
      end
    end
  end

  task automatic scan_clear();
    scan_pos    = '0;
    method_live = '1;
    url_state   = PH_WAIT;
    url_count   = '0;
    key_count   = '0;
    host_state  = PH_WAIT;
    host_count  = '0;
    too_long    = 1'b0;
  endtask

  task automatic scan_byte(input in_item_t it, output bit has_result, output out_item_t res);
    logic [7:0] b;
    b = it.data_byte;
    res = '0;
    res.done_res = it.last;
    res.method = METH_UNKNOWN;
    for (int m = 0; m < NUM_METHODS; m++)
      if (method_live[m] && scan_pos < METHOD_LEN[m] && b != METHOD_TEXT[m][scan_pos])
        method_live[m] = 1'b0;
    if (scan_pos != 4'd15) scan_pos++;

    if (url_state == PH_INSIDE) begin
      if (b == CH_SPACE) begin
        url_state = PH_ENDED;
      end else if (url_count < URL_MAX - 1) begin
        res.url_valid = 1'b1;
        res.url_byte = b;
        url_count++;
      end else begin
        too_long = 1'b1;
      end
    end else if (url_state == PH_WAIT && b == CH_SPACE) begin
      url_state = PH_INSIDE;
    end

    if (host_state == PH_INSIDE) begin
      if (b == CH_NL) begin
        host_state = PH_ENDED;
      end else if (host_count < HOST_MAX - 1) begin
        res.host_valid = 1'b1;
        res.host_byte = b;
        host_count++;
      end else begin
        too_long = 1'b1;
      end
    end else if (host_state == PH_WAIT) begin
      if (key_count < HOST_KEY_LEN && b == HOST_KEY[key_count]) key_count++;
      else key_count = (b == HOST_KEY[0]) ? 3'd1 : 3'd0;
      if (key_count == HOST_KEY_LEN) host_state = PH_INSIDE;
    end

    if (it.last) begin
      for (int m = 0; m < NUM_METHODS; m++)
        if (res.method == METH_UNKNOWN && method_live[m] && scan_pos >= METHOD_LEN[m])
          res.method = method_t'(m);
      res.accepted = res.method != METH_UNKNOWN && url_state == PH_ENDED
                     && host_state == PH_ENDED && !too_long;
    end
    has_result = res.url_valid || res.host_valid || it.last;
    if (it.last) scan_clear();
  endtask

  task automatic send_item(input in_item_t it, input bit typed, input bit want_acc,
                           input method_t want_meth);
    bit        has_result;
    out_item_t res;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scan_byte(it, has_result, res);
    if (has_result) begin
      if (typed && it.last) begin
        res.accepted = want_acc;
        res.method = want_meth;
      end
      pending_results.push_back(res);
    end
  endtask

  task automatic send_request(input bit typed, input bit want_acc, input method_t want_meth);
    for (int i = 0; i < req_bytes.size(); i++)
      send_item('{data_byte: req_bytes[i], last: (i == req_bytes.size() - 1)},
                typed, want_acc, want_meth);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] any_byte_but(input logic [7:0] avoid);
    logic [7:0] b;
    b = 8'($urandom);
    while (b == avoid) b = 8'($urandom);
    return b;
  endfunction

  task automatic build_request(input int url_size, input bit clean);
    int kind;
    int m;
    int n;
    kind = clean ? 9 : $urandom_range(0, 9);
    req_bytes.delete();
    if (kind == 0) begin
      repeat ($urandom_range(1, 12)) req_bytes.push_back(8'($urandom));
      return;
    end
    m = $urandom_range(0, NUM_METHODS - 1);
    for (int i = 0; i < METHOD_LEN[m]; i++) req_bytes.push_back(METHOD_TEXT[m][i]);
    if (kind == 1) req_bytes[$urandom_range(0, METHOD_LEN[m] - 1)] = 8'($urandom);
    repeat (url_size) req_bytes.push_back(any_byte_but(CH_SPACE));
    req_bytes.push_back(CH_SPACE);
    if (!clean && $urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 6)) req_bytes.push_back(any_byte_but(CH_NL));
      req_bytes.push_back(CH_NL);
    end
    if (kind != 2) begin
      for (int i = 0; i < HOST_KEY_LEN; i++) req_bytes.push_back(HOST_KEY[i]);
      repeat ($urandom_range(0, clean ? HOST_MAX - 1 : HOST_MAX + 2))
        req_bytes.push_back(any_byte_but(CH_NL));
      req_bytes.push_back(CH_NL);
    end
    if (kind == 3) begin
      n = $urandom_range(1, req_bytes.size());
      while (req_bytes.size() > n) void'(req_bytes.pop_back());
    end else if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) req_bytes.push_back(8'($urandom));
    end
  endtask

  initial begin
    logic [7:0] ch;
    int         sent;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    scan_clear();

    for (int r = 0; r < NUM_ROWS; r++) begin
      req_bytes.delete();
      for (int i = 0; i < request_table[r].text.len(); i++) begin
        ch = request_table[r].text[i];
        req_bytes.push_back((ch == ZERO_MARK) ? 8'h00 : ch);
      end
      send_request(request_table[r].typed, request_table[r].acc, request_table[r].meth);
    end
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_pct = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      // long output hold while bytes keep coming
      if (p == 0) hold_req <= ~hold_req;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_request(($urandom_range(0, 3) == 0) ? $urandom_range(8, 40)
                                                  : $urandom_range(0, 6), 1'b0);
        send_request(1'b0, 1'b0, METH_UNKNOWN);
        sent += req_bytes.size();
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) report_mismatch("expected results never arrived");
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
